// ----- design/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the round-robin thread scheduler files.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int THREAD_SLOTS_DEF = 16;
	localparam int SEM_COUNT_DEF    = 8;

	typedef enum logic [2:0] {
		REQ_CREATE   = 3'd0,
		REQ_YIELD    = 3'd1,
		REQ_EXIT     = 3'd2,
		REQ_JOIN     = 3'd3,
		REQ_SEM_INIT = 3'd4,
		REQ_SEM_DOWN = 3'd5,
		REQ_SEM_UP   = 3'd6,
		REQ_NONE     = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		TS_FREE     = 2'd0,
		TS_RUNNABLE = 2'd1,
		TS_RUNNING  = 2'd2,
		TS_SLEEPING = 2'd3
	} tstate_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOSLOT   = 3'd1,
		ST_RANGE    = 3'd2,
		ST_LAST     = 3'd3,
		ST_DEADLOCK = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_QRD  = 2'd1,
		S_EXE  = 2'd2
	} fsm_t;

endpackage

// ----- design/rrts_ram.sv -----
// ----------------------------------------------------------------------------
// rrts_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/round_robin_thread_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread slot states, running thread and binary semaphores with FIFO queues.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         start && !busy         req_type target_tid sem_id init_value
// result    out        done (one cycle)       running_tid new_tid join_done status
//
// A request runs through three steps: semaphore record read, queue head read,
// then execute and write back; the result strobes in the following cycle,
// when a new request may already be taken.
// Reset: slot 0 running, all others free, semaphores zero with empty queues.
// The result cannot be stalled; busy holds requests off while one is at work.
module round_robin_thread_scheduler #(
	parameter int THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF,
	parameter int SEM_COUNT    = rrts_pkg::SEM_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] req_type,
	input  logic [4:0] target_tid,
	input  logic [2:0] sem_id,
	input  logic       init_value,
	output logic       done,
	output logic [3:0] running_tid,
	output logic [3:0] new_tid,
	output logic       join_done,
	output logic [2:0] status
);

	localparam int TW = $clog2(THREAD_SLOTS);
	localparam int CW = $clog2(THREAD_SLOTS + 1);
	localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
	localparam int MW = 1 + CW + TW;

	rrts_pkg::fsm_t    state_q, state_d;
	rrts_pkg::tstate_t ts_q [THREAD_SLOTS];
	rrts_pkg::tstate_t ts_d [THREAD_SLOTS];
	logic [TW-1:0]     current_q, cur_d;
	logic [(1<<SW)-1:0] sem_v_q;

	rrts_pkg::req_t req_s1;
	logic [4:0]     tgt_s1;
	logic [2:0]     sid_s1;
	logic           ival_s1;

	logic          m_val_q;
	logic [CW-1:0] m_cnt_q;
	logic [TW-1:0] m_head_q;
	logic          m_val;
	logic [CW-1:0] m_cnt;
	logic [TW-1:0] m_head;

	logic accept, in_qrd, in_exe;

	logic [MW-1:0] meta_rdata, meta_wdata;
	logic          meta_we;
	logic [TW-1:0] q_rdata;
	logic          q_we;
	logic [SW+TW-1:0] q_waddr, q_raddr;
	logic [SW-1:0] sid_idx, in_sid_idx;

	logic          mw_val;
	logic [CW-1:0] mw_cnt;
	logic [TW-1:0] mw_head;
	logic [TW-1:0] tail;

	logic          free_found, other_found;
	logic [TW-1:0] free_idx, other_idx;

	logic [TW-1:0] new_d;
	logic          jd_d;
	rrts_pkg::status_t st_d;

	logic          done_q, jd_q;
	logic [3:0]    run_q, new_q;
	logic [2:0]    st_q;

	assign in_sid_idx = SW'(sem_id);
	assign sid_idx    = SW'(sid_s1);

	// FSM next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrts_pkg::S_IDLE: if (start) state_d = rrts_pkg::S_QRD;
			rrts_pkg::S_QRD:  state_d = rrts_pkg::S_EXE;
			rrts_pkg::S_EXE:  state_d = rrts_pkg::S_IDLE;
			default:          state_d = rrts_pkg::S_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		busy   = 1'b1;
		in_qrd = 1'b0;
		in_exe = 1'b0;
		case (state_q)
			rrts_pkg::S_IDLE: busy = 1'b0;
			rrts_pkg::S_QRD:  in_qrd = 1'b1;
			rrts_pkg::S_EXE:  in_exe = 1'b1;
			default:          busy = 1'b0;
		endcase
	end

	assign accept = start && !busy;

	rrts_ram #(.WIDTH(MW), .DEPTH(1 << SW)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (sid_idx),
		.wdata (meta_wdata),
		.raddr (in_sid_idx),
		.rdata (meta_rdata)
	);

	rrts_ram #(.WIDTH(TW), .DEPTH(1 << (SW + TW))) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (current_q),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// never-written records read as zero
	always_comb begin
		if (sem_v_q[sid_idx]) begin
			{m_val, m_cnt, m_head} = meta_rdata;
		end else begin
			m_val  = 1'b0;
			m_cnt  = '0;
			m_head = '0;
		end
	end

	assign q_raddr = {sid_idx, m_head};

	always_comb begin
		logic [TW:0] sum;
		sum = (TW+1)'(m_head_q) + (TW+1)'(m_cnt_q);
		if (sum >= (TW+1)'(THREAD_SLOTS)) sum = sum - (TW+1)'(THREAD_SLOTS);
		tail = sum[TW-1:0];
	end
	assign q_waddr = {sid_idx, tail};

	// lowest free slot and next runnable slot after the running one
	always_comb begin
		logic [TW:0] idx;
		free_found  = 1'b0;
		free_idx    = '0;
		other_found = 1'b0;
		other_idx   = '0;
		for (int i = 0; i < THREAD_SLOTS; i++) begin
			if (!free_found && ts_q[i] == rrts_pkg::TS_FREE) begin
				free_found = 1'b1;
				free_idx   = TW'(i);
			end
		end
		for (int i = 1; i < THREAD_SLOTS; i++) begin
			idx = (TW+1)'(current_q) + (TW+1)'(i);
			if (idx >= (TW+1)'(THREAD_SLOTS)) idx = idx - (TW+1)'(THREAD_SLOTS);
			if (!other_found && ts_q[idx[TW-1:0]] == rrts_pkg::TS_RUNNABLE) begin
				other_found = 1'b1;
				other_idx   = idx[TW-1:0];
			end
		end
	end

	// execute
	always_comb begin
		logic              yld, sem_ok;
		logic [TW-1:0]     tgt_idx;
		logic [TW:0]       hn;
		rrts_pkg::tstate_t saved;
		ts_d    = ts_q;
		cur_d   = current_q;
		new_d   = '0;
		jd_d    = 1'b0;
		st_d    = rrts_pkg::ST_OK;
		meta_we = 1'b0;
		q_we    = 1'b0;
		mw_val  = m_val_q;
		mw_cnt  = m_cnt_q;
		mw_head = m_head_q;
		yld     = 1'b0;
		sem_ok  = 32'(sid_s1) < SEM_COUNT;
		tgt_idx = TW'(tgt_s1);
		saved   = ts_q[current_q];
		hn      = (TW+1)'(m_head_q) + (TW+1)'(1);
		if (hn >= (TW+1)'(THREAD_SLOTS)) hn = hn - (TW+1)'(THREAD_SLOTS);
		case (req_s1)
			rrts_pkg::REQ_CREATE: begin
				if (free_found) begin
					ts_d[free_idx] = rrts_pkg::TS_RUNNABLE;
					new_d          = free_idx;
				end else begin
					st_d = rrts_pkg::ST_NOSLOT;
				end
			end
			rrts_pkg::REQ_YIELD: yld = 1'b1;
			rrts_pkg::REQ_EXIT: begin
				if (other_found) begin
					ts_d[current_q] = rrts_pkg::TS_FREE;
					ts_d[other_idx] = rrts_pkg::TS_RUNNING;
					cur_d           = other_idx;
				end else begin
					st_d = rrts_pkg::ST_LAST;
				end
			end
			rrts_pkg::REQ_JOIN: begin
				if (32'(tgt_s1) >= THREAD_SLOTS) begin
					st_d = rrts_pkg::ST_RANGE;
				end else if (ts_q[tgt_idx] == rrts_pkg::TS_FREE) begin
					jd_d = 1'b1;
				end else begin
					yld = 1'b1;
				end
			end
			rrts_pkg::REQ_SEM_INIT: begin
				if (sem_ok) begin
					meta_we = 1'b1;
					mw_val  = ival_s1;
					mw_cnt  = '0;
				end
			end
			rrts_pkg::REQ_SEM_DOWN: begin
				if (sem_ok) begin
					if (m_val_q) begin
						meta_we = 1'b1;
						mw_val  = 1'b0;
					end else if (other_found && 32'(m_cnt_q) < THREAD_SLOTS) begin
						meta_we         = 1'b1;
						q_we            = 1'b1;
						mw_cnt          = m_cnt_q + CW'(1);
						ts_d[current_q] = rrts_pkg::TS_SLEEPING;
						ts_d[other_idx] = rrts_pkg::TS_RUNNING;
						cur_d           = other_idx;
					end else begin
						st_d = rrts_pkg::ST_DEADLOCK;
					end
				end
			end
			rrts_pkg::REQ_SEM_UP: begin
				if (sem_ok && !m_val_q) begin
					meta_we = 1'b1;
					if (m_cnt_q == '0) begin
						mw_val = 1'b1;
					end else begin
						ts_d[q_rdata] = rrts_pkg::TS_RUNNABLE;
						mw_head       = hn[TW-1:0];
						mw_cnt        = m_cnt_q - CW'(1);
					end
				end
			end
			default: ;
		endcase
		if (yld) begin
			if (other_found) begin
				if (saved == rrts_pkg::TS_RUNNING) ts_d[current_q] = rrts_pkg::TS_RUNNABLE;
				ts_d[other_idx] = rrts_pkg::TS_RUNNING;
				cur_d           = other_idx;
			end else if (saved == rrts_pkg::TS_RUNNABLE) begin
				ts_d[current_q] = rrts_pkg::TS_RUNNING;
			end else if (saved != rrts_pkg::TS_RUNNING) begin
				st_d = rrts_pkg::ST_DEADLOCK;
			end
		end
		meta_we    = meta_we && in_exe;
		q_we       = q_we && in_exe;
		meta_wdata = {mw_val, mw_cnt, mw_head};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rrts_pkg::S_IDLE;
			current_q <= '0;
			sem_v_q   <= '0;
			done_q    <= 1'b0;
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				ts_q[i] <= (i == 0) ? rrts_pkg::TS_RUNNING : rrts_pkg::TS_FREE;
			end
		end else begin
			state_q <= state_d;
			done_q  <= in_exe;
			if (in_exe) begin
				ts_q      <= ts_d;
				current_q <= cur_d;
				if (meta_we) sem_v_q[sid_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= rrts_pkg::req_t'(req_type);
			tgt_s1  <= target_tid;
			sid_s1  <= sem_id;
			ival_s1 <= init_value;
		end
		if (in_qrd) begin
			m_val_q  <= m_val;
			m_cnt_q  <= m_cnt;
			m_head_q <= m_head;
		end
		if (in_exe) begin
			run_q <= 4'(cur_d);
			new_q <= 4'(new_d);
			jd_q  <= jd_d;
			st_q  <= st_d;
		end
	end

	assign done        = done_q;
	assign running_tid = run_q;
	assign new_tid     = new_q;
	assign join_done   = jd_q;
	assign status      = st_q;

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == rrts_pkg::S_QRD)
		else $error("accepted request did not advance to queue read");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == rrts_pkg::S_IDLE)
		else $error("result strobe while a request is at work");

	a_cur_running: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ts_q[current_q] == rrts_pkg::TS_RUNNING)
		else $error("current thread is not in the running state");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives scheduler requests (directed, then random in mixed idle phases) and
// compares every result strobe against a behavioral thread/semaphore predictor.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NSLOT = 16;
	localparam int NSEM  = 8;
	localparam int LIMIT = 400000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] req_type;
	logic [4:0] target_tid;
	logic [2:0] sem_id;
	logic       init_value;
	logic       done;
	logic [3:0] running_tid;
	logic [3:0] new_tid;
	logic       join_done;
	logic [2:0] status;

	typedef struct packed {
		logic [3:0]        running;
		logic [3:0]        created;
		logic              joined;
		rrts_pkg::status_t st;
	} sched_result_t;

	rrts_pkg::tstate_t slot_state [NSLOT];
	logic [3:0]        cur_slot;
	logic              sem_val [NSEM];
	int                sem_waiters [NSEM];
	logic [3:0]        sem_fifo [NSEM][NSLOT];
	sched_result_t     pending_results [$];

	int errors;
	int cycles;
	int sent;
	int checked;
	int idle_pct;

	round_robin_thread_scheduler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .target_tid(target_tid), .sem_id(sem_id),
		.init_value(init_value), .done(done), .running_tid(running_tid),
		.new_tid(new_tid), .join_done(join_done), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int next_ready();
		int idx;
		for (int i = 1; i <= NSLOT; i++) begin
			idx = (cur_slot + i) % NSLOT;
			if (slot_state[idx] == rrts_pkg::TS_RUNNABLE)
				return idx;
		end
		return -1;
	endfunction

	function automatic rrts_pkg::status_t sched_yield();
		rrts_pkg::tstate_t saved;
		int n;
		saved = slot_state[cur_slot];
		if (saved == rrts_pkg::TS_RUNNING)
			slot_state[cur_slot] = rrts_pkg::TS_RUNNABLE;
		n = next_ready();
		if (n < 0) begin
			slot_state[cur_slot] = saved;
			return rrts_pkg::ST_DEADLOCK;
		end
		slot_state[n] = rrts_pkg::TS_RUNNING;
		cur_slot = n[3:0];
		return rrts_pkg::ST_OK;
	endfunction

	function automatic sched_result_t schedule(rrts_pkg::req_t rq, logic [4:0] tgt,
			logic [2:0] sid, logic ival);
		sched_result_t r;
		int n;
		r = '0;
		r.st = rrts_pkg::ST_OK;
		case (rq)
			rrts_pkg::REQ_CREATE: begin
				r.st = rrts_pkg::ST_NOSLOT;
				for (int i = 0; i < NSLOT; i++) begin
					if (slot_state[i] == rrts_pkg::TS_FREE) begin
						slot_state[i] = rrts_pkg::TS_RUNNABLE;
						r.created = i[3:0];
						r.st = rrts_pkg::ST_OK;
						break;
					end
				end
			end
			rrts_pkg::REQ_YIELD: r.st = sched_yield();
			rrts_pkg::REQ_EXIT: begin
				n = next_ready();
				if (n < 0 || n == cur_slot) begin
					r.st = rrts_pkg::ST_LAST;
				end else begin
					slot_state[cur_slot] = rrts_pkg::TS_FREE;
					slot_state[n] = rrts_pkg::TS_RUNNING;
					cur_slot = n[3:0];
				end
			end
			rrts_pkg::REQ_JOIN: begin
				if (tgt >= NSLOT)
					r.st = rrts_pkg::ST_RANGE;
				else if (slot_state[tgt] == rrts_pkg::TS_FREE)
					r.joined = 1'b1;
				else
					r.st = sched_yield();
			end
			rrts_pkg::REQ_SEM_INIT: begin
				sem_val[sid] = ival;
				sem_waiters[sid] = 0;
			end
			rrts_pkg::REQ_SEM_DOWN: begin
				if (sem_val[sid]) begin
					sem_val[sid] = 1'b0;
				end else begin
					n = next_ready();
					if (n < 0 || n == cur_slot || sem_waiters[sid] >= NSLOT) begin
						r.st = rrts_pkg::ST_DEADLOCK;
					end else begin
						sem_fifo[sid][sem_waiters[sid]] = cur_slot;
						sem_waiters[sid]++;
						slot_state[cur_slot] = rrts_pkg::TS_SLEEPING;
						slot_state[n] = rrts_pkg::TS_RUNNING;
						cur_slot = n[3:0];
					end
				end
			end
			rrts_pkg::REQ_SEM_UP: begin
				if (!sem_val[sid]) begin
					if (sem_waiters[sid] == 0) begin
						sem_val[sid] = 1'b1;
					end else begin
						slot_state[sem_fifo[sid][0]] = rrts_pkg::TS_RUNNABLE;
						for (int i = 1; i < sem_waiters[sid]; i++)
							sem_fifo[sid][i - 1] = sem_fifo[sid][i];
						sem_waiters[sid]--;
					end
				end
			end
			default: ;
		endcase
		r.running = cur_slot;
		return r;
	endfunction

	task automatic send_request(rrts_pkg::req_t rq, logic [4:0] tgt, logic [2:0] sid,
			logic ival);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= rq;
		target_tid <= tgt;
		sem_id     <= sid;
		init_value <= ival;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(schedule(rq, tgt, sid, ival));
		sent++;
	endtask

	// check each result transfer against the oldest prediction
	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = pending_results.pop_front();
				checked++;
				if (running_tid !== e.running) begin
					$error("running_tid expected %0d got %0d", e.running, running_tid);
					errors++;
				end
				if (new_tid !== e.created) begin
					$error("new_tid expected %0d got %0d", e.created, new_tid);
					errors++;
				end
				if (join_done !== e.joined) begin
					$error("join_done expected %0d got %0d", e.joined, join_done);
					errors++;
				end
				if (status !== e.st) begin
					$error("status expected %0d got %0d", e.st, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("round_robin_thread_scheduler test failed");
			$finish;
		end
	end

	task automatic test_directed();
		idle_pct = 0;
		send_request(rrts_pkg::REQ_EXIT, 5'd0, 3'd0, 1'b0);
		send_request(rrts_pkg::REQ_YIELD, 5'd0, 3'd0, 1'b0);
		send_request(rrts_pkg::REQ_JOIN, 5'd31, 3'd0, 1'b0);
		send_request(rrts_pkg::REQ_JOIN, 5'd16, 3'd0, 1'b0);
		send_request(rrts_pkg::REQ_JOIN, 5'd15, 3'd0, 1'b0);
		send_request(rrts_pkg::REQ_JOIN, 5'd0, 3'd0, 1'b0);
		send_request(rrts_pkg::REQ_SEM_DOWN, 5'd0, 3'd7, 1'b0);
		send_request(rrts_pkg::REQ_SEM_UP, 5'd0, 3'd7, 1'b0);
		send_request(rrts_pkg::REQ_SEM_UP, 5'd0, 3'd7, 1'b0);
		send_request(rrts_pkg::REQ_SEM_DOWN, 5'd0, 3'd7, 1'b0);
		for (int i = 0; i < 16; i++)
			send_request(rrts_pkg::REQ_CREATE, 5'd0, 3'd0, 1'b0);
		send_request(rrts_pkg::REQ_SEM_DOWN, 5'd0, 3'd7, 1'b0);
		send_request(rrts_pkg::REQ_SEM_INIT, 5'd0, 3'd7, 1'b1);
		send_request(rrts_pkg::REQ_NONE, 5'd0, 3'd0, 1'b0);
		send_request(rrts_pkg::REQ_EXIT, 5'd0, 3'd0, 1'b0);
	endtask

	task automatic test_random(int count, int pct);
		int pick;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 15)
				send_request(rrts_pkg::REQ_CREATE, 5'($urandom), 3'($urandom),
					1'($urandom));
			else if (pick < 30)
				send_request(rrts_pkg::REQ_YIELD, 5'($urandom), 3'($urandom),
					1'($urandom));
			else if (pick < 40)
				send_request(rrts_pkg::REQ_EXIT, 5'($urandom), 3'($urandom),
					1'($urandom));
			else if (pick < 52)
				send_request(rrts_pkg::REQ_JOIN, 5'($urandom), 3'($urandom),
					1'($urandom));
			else if (pick < 58)
				send_request(rrts_pkg::REQ_SEM_INIT, 5'($urandom),
					3'($urandom_range(3)), 1'($urandom));
			else if (pick < 78)
				send_request(rrts_pkg::REQ_SEM_DOWN, 5'($urandom),
					3'($urandom_range(3)), 1'($urandom));
			else if (pick < 96)
				send_request(rrts_pkg::REQ_SEM_UP, 5'($urandom),
					3'($urandom_range(3)), 1'($urandom));
			else
				send_request(rrts_pkg::req_t'(3'($urandom)), 5'($urandom),
					3'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		sent = 0;
		checked = 0;
		idle_pct = 0;
		for (int i = 0; i < NSLOT; i++)
			slot_state[i] = rrts_pkg::TS_FREE;
		slot_state[0] = rrts_pkg::TS_RUNNING;
		cur_slot = '0;
		for (int s = 0; s < NSEM; s++) begin
			sem_val[s] = 1'b0;
			sem_waiters[s] = 0;
		end
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = 3'd0;
		target_tid = 5'd0;
		sem_id     = 3'd0;
		init_value = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, 0);
		test_random(120, 81);
		test_random(120, 28);
		test_random(110, 0);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("sent %0d requests (create, yield, exit, join, semaphores), checked %0d results",
			sent, checked);
		if (errors == 0 && pending_results.size() == 0)
			$display("round_robin_thread_scheduler test passed");
		else
			$display("round_robin_thread_scheduler test failed");
		$finish;
	end

endmodule
